### src/tbm_pkg.sv
`timescale 1ns / 1ps
package tbm_pkg;
   localparam int SLOT_COUNT_DEFAULT = 16;
   localparam int RESULT_LIMIT = 16;
   localparam logic [3:0] CMD_TICK = 4'd0;
   localparam logic [3:0] CMD_CREATE = 4'd1;
   localparam logic [3:0] CMD_DELETE = 4'd2;
   localparam logic [3:0] CMD_START = 4'd3;
   localparam logic [3:0] CMD_STOP = 4'd4;
   localparam logic [3:0] CMD_RESET = 4'd5;
   localparam logic [3:0] CMD_SETPER = 4'd6;
   localparam logic [3:0] CMD_QUERY = 4'd7;
   localparam logic [3:0] CMD_STATS = 4'd8;
   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_INVALID = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;
endpackage

### src/timer_bank_manager.sv
`timescale 1ns / 1ps
// one slot visited per cycle by the shared decrement/compare unit, except that a tick pauses
// the scan in S_EMIT for each expiry after the first, and a waiting word stays in S_EMIT,
// S_ACT or S_OUT for as long as rsp_stall holds it
// a new command is taken only in S_IDLE, after the final word of the previous one is loaded
// reset: synchronous active high; all slots free, next handle 1, counters zero
module timer_bank_manager #(
   parameter int SLOT_COUNT = tbm_pkg::SLOT_COUNT_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [3:0]  req_cmd,
   input  logic [31:0] req_timer_id,
   input  logic [31:0] req_period,
   input  logic        req_periodic,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_handle_out,
   output logic [31:0] rsp_remaining,
   output logic        rsp_active,
   output logic        rsp_expired,
   output logic [6:0]  rsp_live_count,
   output logic [6:0]  rsp_running_count,
   output logic [6:0]  rsp_stopped_count,
   output logic [31:0] rsp_fired_total,
   output logic        rsp_last
);
   localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int CW = $clog2(SLOT_COUNT + 1);
   localparam logic [2:0] S_IDLE = 3'd0, S_SCAN = 3'd1, S_EMIT = 3'd2, S_ACT = 3'd3,
      S_OUT = 3'd4;

   logic [31:0] hnd_ff [SLOT_COUNT];
   logic [31:0] per_ff [SLOT_COUNT];
   logic [31:0] rem_ff [SLOT_COUNT];
   logic [SLOT_COUNT-1:0] run_ff, pmd_ff;

   logic [2:0] state_ff;
   logic [IW-1:0] idx_ff;
   logic [3:0] cmd_ff;
   logic [31:0] id_ff, pin_ff;
   logic pm_ff;
   logic found_ff, free_ff;
   logic [IW-1:0] fidx_ff, fridx_ff;
   logic [CW-1:0] alloc_ff, runc_ff, stpc_ff;
   logic [31:0] next_id_ff, fire_ff;
   logic [4:0] nrep_ff;
   logic pend_ff;
   logic [31:0] pend_h_ff;

   logic [31:0] h_cur, r_cur, r_dec;
   logic at_end, fire_now, rep_now, rsp_load;
   assign h_cur = hnd_ff[idx_ff];
   assign r_cur = rem_ff[idx_ff];
   assign r_dec = (r_cur != 32'd0) ? r_cur - 32'd1 : 32'd0;
   assign at_end = (idx_ff == IW'(SLOT_COUNT - 1));
   assign fire_now = (cmd_ff == tbm_pkg::CMD_TICK) && h_cur != 32'd0 && run_ff[idx_ff]
      && r_dec == 32'd0;
   assign rep_now = fire_now && nrep_ff < 5'(tbm_pkg::RESULT_LIMIT);
   assign rsp_load = (state_ff == S_EMIT || state_ff == S_ACT || state_ff == S_OUT)
      && (!rsp_valid || !rsp_stall);

   assign req_stall = (state_ff != S_IDLE);

   logic [31:0] nid_inc;
   assign nid_inc = (next_id_ff + 32'd1 == 32'd0) ? 32'd1 : next_id_ff + 32'd1;

   // command outcome once the scan is done
   logic [1:0] act_status;
   logic [31:0] act_handle, act_remaining;
   logic act_active;
   always_comb begin
      act_status = tbm_pkg::ST_OK;
      act_handle = 32'd0;
      act_remaining = 32'd0;
      act_active = 1'b0;
      case (cmd_ff)
         tbm_pkg::CMD_CREATE: begin
            if (alloc_ff >= CW'(SLOT_COUNT) || !free_ff) act_status = tbm_pkg::ST_FULL;
            else if (pin_ff == 32'd0) act_status = tbm_pkg::ST_INVALID;
            else act_handle = next_id_ff;
         end
         tbm_pkg::CMD_DELETE, tbm_pkg::CMD_START, tbm_pkg::CMD_STOP,
         tbm_pkg::CMD_RESET: begin
            if (!found_ff) act_status = tbm_pkg::ST_INVALID;
         end
         tbm_pkg::CMD_SETPER: begin
            if (!found_ff || pin_ff == 32'd0) act_status = tbm_pkg::ST_INVALID;
         end
         tbm_pkg::CMD_QUERY: begin
            if (!found_ff) act_status = tbm_pkg::ST_INVALID;
            else begin
               act_remaining = rem_ff[fidx_ff];
               act_active = run_ff[fidx_ff];
            end
         end
         tbm_pkg::CMD_STATS: act_status = tbm_pkg::ST_OK;
         default: act_status = tbm_pkg::ST_INVALID;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         run_ff <= '0;
         pmd_ff <= '0;
         for (int i = 0; i < SLOT_COUNT; i++) begin
            hnd_ff[i] <= 32'd0;
            per_ff[i] <= 32'd0;
            rem_ff[i] <= 32'd0;
         end
         alloc_ff <= '0;
         next_id_ff <= 32'd1;
         fire_ff <= 32'd0;
         rsp_valid <= 1'b0;
         pend_ff <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall && !rsp_load) rsp_valid <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  cmd_ff <= req_cmd;
                  id_ff <= req_timer_id;
                  pin_ff <= req_period;
                  pm_ff <= req_periodic;
                  idx_ff <= '0;
                  found_ff <= 1'b0;
                  free_ff <= 1'b0;
                  runc_ff <= '0;
                  stpc_ff <= '0;
                  nrep_ff <= '0;
                  state_ff <= S_SCAN;
               end
            end
            S_SCAN: begin
               if (cmd_ff == tbm_pkg::CMD_TICK) begin
                  if (h_cur != 32'd0 && run_ff[idx_ff]) begin
                     if (r_dec == 32'd0) begin
                        fire_ff <= fire_ff + 32'd1;
                        if (pmd_ff[idx_ff]) rem_ff[idx_ff] <= per_ff[idx_ff];
                        else begin
                           rem_ff[idx_ff] <= 32'd0;
                           run_ff[idx_ff] <= 1'b0;
                        end
                     end else rem_ff[idx_ff] <= r_dec;
                  end
                  if (rep_now) begin
                     nrep_ff <= nrep_ff + 5'd1;
                     pend_ff <= 1'b1;
                     if (!pend_ff) pend_h_ff <= h_cur;
                  end
                  if (rep_now && pend_ff) state_ff <= S_EMIT;
                  else if (at_end) state_ff <= S_OUT;
                  else idx_ff <= idx_ff + IW'(1);
               end else begin
                  if (id_ff != 32'd0 && h_cur == id_ff && !found_ff) begin
                     found_ff <= 1'b1;
                     fidx_ff <= idx_ff;
                  end
                  if (h_cur == 32'd0 && !free_ff) begin
                     free_ff <= 1'b1;
                     fridx_ff <= idx_ff;
                  end
                  if (h_cur != 32'd0) begin
                     if (run_ff[idx_ff]) runc_ff <= runc_ff + CW'(1);
                     else stpc_ff <= stpc_ff + CW'(1);
                  end
                  if (at_end) state_ff <= S_ACT;
                  else idx_ff <= idx_ff + IW'(1);
               end
            end
            S_EMIT: begin
               // older pending word goes out, current slot's handle becomes pending
               if (rsp_load) begin
                  rsp_valid <= 1'b1;
                  rsp_status <= tbm_pkg::ST_OK;
                  rsp_handle_out <= pend_h_ff;
                  rsp_remaining <= 32'd0;
                  rsp_active <= 1'b0;
                  rsp_expired <= 1'b1;
                  rsp_live_count <= 7'd0;
                  rsp_running_count <= 7'd0;
                  rsp_stopped_count <= 7'd0;
                  rsp_fired_total <= 32'd0;
                  rsp_last <= 1'b0;
                  pend_h_ff <= hnd_ff[idx_ff];
                  if (at_end) state_ff <= S_OUT;
                  else begin
                     idx_ff <= idx_ff + IW'(1);
                     state_ff <= S_SCAN;
                  end
               end
            end
            S_ACT: begin
               if (rsp_load) begin
                  rsp_valid <= 1'b1;
                  rsp_status <= act_status;
                  rsp_handle_out <= act_handle;
                  rsp_remaining <= act_remaining;
                  rsp_active <= act_active;
                  rsp_expired <= 1'b0;
                  rsp_live_count <= (cmd_ff == tbm_pkg::CMD_STATS) ? 7'(alloc_ff) : 7'd0;
                  rsp_running_count <= (cmd_ff == tbm_pkg::CMD_STATS) ? 7'(runc_ff) : 7'd0;
                  rsp_stopped_count <= (cmd_ff == tbm_pkg::CMD_STATS) ? 7'(stpc_ff) : 7'd0;
                  rsp_fired_total <= (cmd_ff == tbm_pkg::CMD_STATS) ? fire_ff : 32'd0;
                  rsp_last <= 1'b1;
                  if (act_status == tbm_pkg::ST_OK) begin
                     case (cmd_ff)
                        tbm_pkg::CMD_CREATE: begin
                           hnd_ff[fridx_ff] <= next_id_ff;
                           per_ff[fridx_ff] <= pin_ff;
                           rem_ff[fridx_ff] <= pin_ff;
                           run_ff[fridx_ff] <= 1'b0;
                           pmd_ff[fridx_ff] <= pm_ff;
                           alloc_ff <= alloc_ff + CW'(1);
                           next_id_ff <= nid_inc;
                        end
                        tbm_pkg::CMD_DELETE: begin
                           hnd_ff[fidx_ff] <= 32'd0;
                           per_ff[fidx_ff] <= 32'd0;
                           rem_ff[fidx_ff] <= 32'd0;
                           run_ff[fidx_ff] <= 1'b0;
                           pmd_ff[fidx_ff] <= 1'b0;
                           if (alloc_ff != '0) alloc_ff <= alloc_ff - CW'(1);
                        end
                        tbm_pkg::CMD_START: begin
                           if (!run_ff[fidx_ff]) begin
                              run_ff[fidx_ff] <= 1'b1;
                              rem_ff[fidx_ff] <= per_ff[fidx_ff];
                           end
                        end
                        tbm_pkg::CMD_STOP: run_ff[fidx_ff] <= 1'b0;
                        tbm_pkg::CMD_RESET: begin
                           rem_ff[fidx_ff] <= per_ff[fidx_ff];
                           run_ff[fidx_ff] <= 1'b1;
                        end
                        tbm_pkg::CMD_SETPER: begin
                           per_ff[fidx_ff] <= pin_ff;
                           if (run_ff[fidx_ff]) rem_ff[fidx_ff] <= pin_ff;
                        end
                        default: ;
                     endcase
                  end
                  state_ff <= S_IDLE;
               end
            end
            S_OUT: begin
               // final word of a tick
               if (rsp_load) begin
                  rsp_valid <= 1'b1;
                  rsp_status <= tbm_pkg::ST_OK;
                  rsp_handle_out <= pend_ff ? pend_h_ff : 32'd0;
                  rsp_remaining <= 32'd0;
                  rsp_active <= 1'b0;
                  rsp_expired <= pend_ff;
                  rsp_live_count <= 7'd0;
                  rsp_running_count <= 7'd0;
                  rsp_stopped_count <= 7'd0;
                  rsp_fired_total <= 32'd0;
                  rsp_last <= 1'b1;
                  pend_ff <= 1'b0;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
module testbench;

   localparam int NSLOT = tbm_pkg::SLOT_COUNT_DEFAULT;

   typedef struct packed {
      logic [3:0]  cmd;
      logic [31:0] timer_id;
      logic [31:0] period;
      logic        periodic;
   } cmd_word_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] handle_out;
      logic [31:0] remaining;
      logic        active;
      logic        expired;
      logic [6:0]  live_count;
      logic [6:0]  running_count;
      logic [6:0]  stopped_count;
      logic [31:0] fired_total;
      logic        last;
   } rsp_word_type;

   typedef struct {
      cmd_word_type w;
      bit           typed;
      rsp_word_type exp;
   } dir_row_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic [3:0] req_cmd = '0;
   logic [31:0] req_timer_id = '0;
   logic [31:0] req_period = '0;
   logic req_periodic = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic [1:0] rsp_status;
   logic [31:0] rsp_handle_out, rsp_remaining, rsp_fired_total;
   logic rsp_active, rsp_expired, rsp_last;
   logic [6:0] rsp_live_count, rsp_running_count, rsp_stopped_count;

   timer_bank_manager uut (.*);

   always #5 clock = ~clock;

   // timer bank mirror
   logic [31:0] t_handle [NSLOT];
   logic [31:0] t_period [NSLOT];
   logic [31:0] t_remain [NSLOT];
   bit          t_run [NSLOT];
   bit          t_periodic [NSLOT];
   int          t_alloc;
   logic [31:0] t_next_id;
   logic [31:0] t_fired;

   rsp_word_type expected_words[$];
   int errors = 0;
   bit hold_off = 0;

   function automatic int find_slot(logic [31:0] h);
      if (h == 0) return -1;
      for (int i = 0; i < NSLOT; i++)
         if (t_handle[i] == h) return i;
      return -1;
   endfunction

   function automatic rsp_word_type blank_word();
      rsp_word_type r;
      r = '0;
      r.status = tbm_pkg::ST_OK;
      r.last = 1'b1;
      return r;
   endfunction

   task automatic predict_bank(input cmd_word_type w);
      rsp_word_type r;
      int s, n, i, run, stp;
      rsp_word_type ticks[$];
      r = blank_word();
      if (w.cmd == tbm_pkg::CMD_TICK) begin
         for (i = 0; i < NSLOT; i++) begin
            if (t_handle[i] == 0 || !t_run[i]) continue;
            if (t_remain[i] > 0) t_remain[i]--;
            if (t_remain[i] == 0) begin
               t_fired++;
               if (ticks.size() < tbm_pkg::RESULT_LIMIT) begin
                  r = '0;
                  r.handle_out = t_handle[i];
                  r.expired = 1'b1;
                  ticks.push_back(r);
               end
               if (t_periodic[i]) t_remain[i] = t_period[i];
               else t_run[i] = 1'b0;
            end
         end
         if (ticks.size() == 0) ticks.push_back(blank_word());
         ticks[ticks.size() - 1].last = 1'b1;
         foreach (ticks[k]) expected_words.push_back(ticks[k]);
         return;
      end
      s = find_slot(w.timer_id);
      case (w.cmd)
         tbm_pkg::CMD_CREATE: begin
            n = -1;
            for (i = NSLOT - 1; i >= 0; i--)
               if (t_handle[i] == 0) n = i;
            if (t_alloc >= NSLOT) r.status = tbm_pkg::ST_FULL;
            else if (w.period == 0) r.status = tbm_pkg::ST_INVALID;
            else if (n < 0) r.status = tbm_pkg::ST_FULL;
            else begin
               t_handle[n] = t_next_id;
               t_period[n] = w.period;
               t_remain[n] = w.period;
               t_run[n] = 1'b0;
               t_periodic[n] = w.periodic;
               t_alloc++;
               r.handle_out = t_next_id;
               t_next_id++;
               if (t_next_id == 0) t_next_id = 1;
            end
         end
         tbm_pkg::CMD_DELETE: begin
            if (s < 0) r.status = tbm_pkg::ST_INVALID;
            else begin
               t_handle[s] = 0; t_period[s] = 0; t_remain[s] = 0;
               t_run[s] = 1'b0; t_periodic[s] = 1'b0;
               if (t_alloc > 0) t_alloc--;
            end
         end
         tbm_pkg::CMD_START: begin
            if (s < 0) r.status = tbm_pkg::ST_INVALID;
            else if (!t_run[s]) begin
               t_run[s] = 1'b1;
               t_remain[s] = t_period[s];
            end
         end
         tbm_pkg::CMD_STOP: begin
            if (s < 0) r.status = tbm_pkg::ST_INVALID;
            else t_run[s] = 1'b0;
         end
         tbm_pkg::CMD_RESET: begin
            if (s < 0) r.status = tbm_pkg::ST_INVALID;
            else begin
               t_remain[s] = t_period[s];
               t_run[s] = 1'b1;
            end
         end
         tbm_pkg::CMD_SETPER: begin
            if (s < 0 || w.period == 0) r.status = tbm_pkg::ST_INVALID;
            else begin
               t_period[s] = w.period;
               if (t_run[s]) t_remain[s] = w.period;
            end
         end
         tbm_pkg::CMD_QUERY: begin
            if (s < 0) r.status = tbm_pkg::ST_INVALID;
            else begin
               r.remaining = t_remain[s];
               r.active = t_run[s];
            end
         end
         tbm_pkg::CMD_STATS: begin
            run = 0; stp = 0;
            for (i = 0; i < NSLOT; i++)
               if (t_handle[i] != 0) begin
                  if (t_run[i]) run++;
                  else stp++;
               end
            r.live_count = 7'(t_alloc);
            r.running_count = 7'(run);
            r.stopped_count = 7'(stp);
            r.fired_total = t_fired;
         end
         default: r.status = tbm_pkg::ST_INVALID;
      endcase
      expected_words.push_back(r);
   endtask

   // advance mirror state for rows whose word is typed in
   task automatic predict_quiet(input cmd_word_type w);
      predict_bank(w);
      void'(expected_words.pop_back());
   endtask

   task automatic send_word(input cmd_word_type w);
      req_valid <= 1;
      req_cmd <= w.cmd;
      req_timer_id <= w.timer_id;
      req_period <= w.period;
      req_periodic <= w.periodic;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic gap_cycles(input int n);
      if (n > 0) begin
         req_valid <= 0;
         repeat (n) @(posedge clock);
      end
   endtask

   // random handle: mostly live, sometimes stale or absent
   function automatic logic [31:0] pick_handle();
      int live[$];
      for (int i = 0; i < NSLOT; i++)
         if (t_handle[i] != 0) live.push_back(i);
      case ($urandom_range(9))
         0: return 0;
         1: return $urandom();
         2: return t_next_id - 1 - $urandom_range(3);
         default: return live.size() ? t_handle[live[$urandom_range(live.size() - 1)]]
                                      : $urandom_range(5);
      endcase
   endfunction

   function automatic logic [31:0] pick_period();
      case ($urandom_range(9))
         0: return 0;
         1: return 32'hFFFF_FFFF - $urandom_range(3);
         2: return $urandom();
         default: return $urandom_range(1, 6);
      endcase
   endfunction

   function automatic logic [3:0] pick_cmd();
      int k;
      k = $urandom_range(99);
      if (k < 35) return tbm_pkg::CMD_TICK;
      if (k < 50) return tbm_pkg::CMD_CREATE;
      if (k < 56) return tbm_pkg::CMD_DELETE;
      if (k < 70) return tbm_pkg::CMD_START;
      if (k < 74) return tbm_pkg::CMD_STOP;
      if (k < 79) return tbm_pkg::CMD_RESET;
      if (k < 84) return tbm_pkg::CMD_SETPER;
      if (k < 91) return tbm_pkg::CMD_QUERY;
      if (k < 97) return tbm_pkg::CMD_STATS;
      return 4'($urandom_range(9, 15));
   endfunction

   // response checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_word_type e;
         if (expected_words.size() == 0) begin
            $error("unexpected word, handle_out %0h", rsp_handle_out);
            errors++;
         end else begin
            e = expected_words.pop_front();
            if (rsp_status !== e.status) begin
               $error("status exp %0d got %0d", e.status, rsp_status); errors++;
            end
            if (rsp_handle_out !== e.handle_out) begin
               $error("handle_out exp %0h got %0h", e.handle_out, rsp_handle_out); errors++;
            end
            if (rsp_remaining !== e.remaining) begin
               $error("remaining exp %0h got %0h", e.remaining, rsp_remaining); errors++;
            end
            if (rsp_active !== e.active) begin
               $error("active exp %0d got %0d", e.active, rsp_active); errors++;
            end
            if (rsp_expired !== e.expired) begin
               $error("expired exp %0d got %0d", e.expired, rsp_expired); errors++;
            end
            if (rsp_live_count !== e.live_count) begin
               $error("live_count exp %0d got %0d", e.live_count, rsp_live_count); errors++;
            end
            if (rsp_running_count !== e.running_count) begin
               $error("running_count exp %0d got %0d", e.running_count, rsp_running_count);
               errors++;
            end
            if (rsp_stopped_count !== e.stopped_count) begin
               $error("stopped_count exp %0d got %0d", e.stopped_count, rsp_stopped_count);
               errors++;
            end
            if (rsp_fired_total !== e.fired_total) begin
               $error("fired_total exp %0h got %0h", e.fired_total, rsp_fired_total); errors++;
            end
            if (rsp_last !== e.last) begin
               $error("last exp %0d got %0d", e.last, rsp_last); errors++;
            end
         end
      end
   end

   // receiver stall pattern
   always @(posedge clock) begin
      int k;
      k = $urandom_range(15);
      if (hold_off) rsp_stall <= 1;
      else if (k < 3) rsp_stall <= 1;
      else if (k < 5) rsp_stall <= ($urandom_range(1) == 1);
      else rsp_stall <= 0;
   end

   initial begin
      #20ms;
      $display("testbench: FAIL");
      $finish;
   end

   // long receiver hold-off while the sender keeps offering
   initial begin
      int c;
      wait (!reset);
      repeat (1500) @(posedge clock);
      hold_off <= 1;
      c = 0;
      while (c < 400) begin
         @(posedge clock);
         c++;
      end
      hold_off <= 0;
   end

   initial begin
      dir_row_type rows[$];
      dir_row_type d;
      cmd_word_type w;
      rsp_word_type e;
      int burst;

      for (int i = 0; i < NSLOT; i++) begin
         t_handle[i] = 0; t_period[i] = 0; t_remain[i] = 0;
         t_run[i] = 0; t_periodic[i] = 0;
      end
      t_alloc = 0; t_next_id = 1; t_fired = 0;

      // directed table
      e = blank_word();
      d.typed = 1; d.exp = e;
      d.w = '{tbm_pkg::CMD_TICK, 0, 0, 0}; rows.push_back(d);
      d.exp = e; d.exp.status = tbm_pkg::ST_INVALID;
      d.w = '{tbm_pkg::CMD_QUERY, 0, 0, 0}; rows.push_back(d);
      d.w = '{tbm_pkg::CMD_CREATE, 0, 0, 1}; rows.push_back(d);
      d.w = '{4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1}; rows.push_back(d);
      d.w = '{4'd9, 0, 0, 0}; rows.push_back(d);
      d.w = '{tbm_pkg::CMD_DELETE, 32'hFFFF_FFFF, 0, 0}; rows.push_back(d);
      d.exp = e; d.exp.handle_out = 1;
      d.w = '{tbm_pkg::CMD_CREATE, 0, 1, 0}; rows.push_back(d);
      d.exp = e; d.exp.handle_out = 2;
      d.w = '{tbm_pkg::CMD_CREATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1}; rows.push_back(d);
      d.typed = 0;
      d.w = '{tbm_pkg::CMD_CREATE, 0, 2, 1}; rows.push_back(d);
      d.w = '{tbm_pkg::CMD_START, 1, 0, 0}; rows.push_back(d);
      d.w = '{tbm_pkg::CMD_START, 1, 0, 0}; rows.push_back(d);
      d.w = '{tbm_pkg::CMD_START, 3, 0, 0}; rows.push_back(d);
      d.w = '{tbm_pkg::CMD_STOP, 2, 0, 0}; rows.push_back(d);
      d.w = '{tbm_pkg::CMD_TICK, 0, 0, 0}; rows.push_back(d);
      d.w = '{tbm_pkg::CMD_TICK, 0, 0, 0}; rows.push_back(d);
      d.w = '{tbm_pkg::CMD_RESET, 2, 0, 0}; rows.push_back(d);
      d.w = '{tbm_pkg::CMD_SETPER, 3, 0, 0}; rows.push_back(d);
      d.w = '{tbm_pkg::CMD_SETPER, 3, 1, 0}; rows.push_back(d);
      d.w = '{tbm_pkg::CMD_QUERY, 2, 0, 0}; rows.push_back(d);
      d.w = '{tbm_pkg::CMD_TICK, 0, 0, 0}; rows.push_back(d);
      d.w = '{tbm_pkg::CMD_STATS, 0, 0, 0}; rows.push_back(d);
      d.w = '{tbm_pkg::CMD_DELETE, 1, 0, 0}; rows.push_back(d);
      d.w = '{tbm_pkg::CMD_QUERY, 1, 0, 0}; rows.push_back(d);
      for (int i = 0; i < 16; i++) begin
         d.w = '{tbm_pkg::CMD_CREATE, 0, 1, 1}; rows.push_back(d);
      end
      d.w = '{tbm_pkg::CMD_STATS, 0, 0, 0}; rows.push_back(d);

      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      foreach (rows[r]) begin
         if (rows[r].typed) expected_words.push_back(rows[r].exp);
         else predict_bank(rows[r].w);
         if (rows[r].typed) predict_quiet(rows[r].w);
         send_word(rows[r].w);
      end
      // many timers firing in one tick
      for (int i = 0; i < NSLOT; i++) begin
         w = '{tbm_pkg::CMD_START, t_handle[i], 0, 0};
         predict_bank(w);
         send_word(w);
      end
      w = '{tbm_pkg::CMD_TICK, 0, 0, 0}; predict_bank(w); send_word(w);
      // drain bank so random part starts from a mix
      for (int i = 0; i < 12; i++) begin
         w = '{tbm_pkg::CMD_DELETE, t_handle[i], 0, 0};
         predict_bank(w);
         send_word(w);
      end

      // random bursts
      burst = 0;
      for (int n = 0; n < 130; n++) begin
         w.cmd = pick_cmd();
         w.timer_id = pick_handle();
         w.period = pick_period();
         w.periodic = 1'($urandom_range(1));
         if (n % 8 == 0) w.timer_id[31:16] = 16'($urandom());
         predict_bank(w);
         send_word(w);
         if (burst == 0) begin
            gap_cycles(n < 100 ? $urandom_range(0, 40) : 0);
            burst = $urandom_range(1, 8);
         end else burst--;
      end
      req_valid <= 0;

      while (expected_words.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (errors == 0) $display("testbench: PASS");
      else $display("testbench: FAIL");
      $finish;
   end

endmodule

### sim.f
src/tbm_pkg.sv
src/timer_bank_manager.sv
tb/testbench.sv
